>>> design/kwdf_pkg.sv
// Package for the k-mer window low-complexity filter.
// Holds payload structs, field widths, register indexes and the dimer control struct.
// No dependencies.
package kwdf_pkg;

  localparam int BASE_W     = 3;
  localparam int KLEN_W     = 6;
  localparam int PSUM_W     = 10;
  localparam int CNT_W      = 5;
  localparam int DIMER_W    = 4;
  localparam int NUM_DIMERS = 16;
  localparam int KMER_W     = 64;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_KMER_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PAIR_SUM = 1'b1;

  localparam logic [KLEN_W-1:0] KLEN_RESET     = 6'd16;
  localparam logic [PSUM_W-1:0] MIN_PSUM_RESET = 10'd28;
  localparam logic [KLEN_W-1:0] KLEN_MIN       = 6'd2;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic              read_end;
  } kwdf_in_t;

  typedef struct packed {
    logic [KMER_W-1:0] kmer_bits;
    logic [PSUM_W-1:0] pair_sum;
    logic              dust_flag;
  } kwdf_out_t;

  // Control from the window logic to the dimer count bank.
  typedef struct packed {
    logic               upd;
    logic               clr;
    logic               dec_en;
    logic [DIMER_W-1:0] dec_idx;
    logic               inc_en;
    logic [DIMER_W-1:0] inc_idx;
  } kwdf_dimer_ctl_t;

endpackage

>>> design/kwdf_dimer_bank.sv
// Dimer count bank: 16 five-bit counters and the running pair sum.
// Depends on kwdf_pkg.
module kwdf_dimer_bank (
  input  logic                               clk,
  input  logic                               rst_n,
  input  kwdf_pkg::kwdf_dimer_ctl_t          ctl,
  output logic [kwdf_pkg::PSUM_W-1:0]        pair_sum_nxt
);
  import kwdf_pkg::*;

  logic [CNT_W-1:0]  cnt_r   [NUM_DIMERS];
  logic [CNT_W-1:0]  cnt_nxt [NUM_DIMERS];
  logic [PSUM_W-1:0] sub_lane [NUM_DIMERS];
  logic [PSUM_W-1:0] add_lane [NUM_DIMERS];
  logic [PSUM_W-1:0] psum_r;
  logic [PSUM_W-1:0] sub_sum;
  logic [PSUM_W-1:0] add_sum;

  // Each lane removes the departing dimer first, then adds the arriving one.
  for (genvar i = 0; i < NUM_DIMERS; i++) begin : g_lane
    logic             dec_hit;
    logic             inc_hit;
    logic [CNT_W-1:0] cnt_dec;

    assign dec_hit = ctl.dec_en && (ctl.dec_idx == DIMER_W'(i)) && (cnt_r[i] != '0);
    assign inc_hit = ctl.inc_en && (ctl.inc_idx == DIMER_W'(i));
    assign cnt_dec = dec_hit ? cnt_r[i] - CNT_W'(1) : cnt_r[i];
    assign sub_lane[i] = dec_hit ? PSUM_W'({cnt_dec, 1'b0}) : '0;
    assign add_lane[i] = inc_hit ? PSUM_W'({cnt_dec, 1'b0}) : '0;
    assign cnt_nxt[i]  = inc_hit ? cnt_dec + CNT_W'(1) : cnt_dec;
  end

  // At most one lane drives each term, so an OR collects it.
  always_comb begin
    sub_sum = '0;
    add_sum = '0;
    for (int i = 0; i < NUM_DIMERS; i++) begin
      sub_sum = sub_sum | sub_lane[i];
      add_sum = add_sum | add_lane[i];
    end
    pair_sum_nxt = psum_r - sub_sum + add_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      psum_r <= '0;
      for (int i = 0; i < NUM_DIMERS; i++) cnt_r[i] <= '0;
    end else if (ctl.upd) begin
      psum_r <= pair_sum_nxt;
      for (int i = 0; i < NUM_DIMERS; i++) cnt_r[i] <= cnt_nxt[i];
    end
  end

endmodule

>>> design/kmer_window_dust_filter.sv
// Top level of the k-mer window low-complexity (DUST style) filter.
// Depends on kwdf_pkg and kwdf_dimer_bank.
//
// One base enters per transfer (0..3 = A,C,G,T; 4..7 = N) with a read_end flag.
// The block takes one base every clock cycle while in_stall is low: the whole
// update (window shift, dimer count change, pair sum and threshold compare) is
// one combinational step from the state registers into the result register,
// so a result reaches out_valid in the next cycle. The result register acts as
// the decoupling stage: a new base is taken whenever the result register is empty
// or drained in the same cycle. Once k clean bases follow the read start or
// the last N, each base yields one result: the packed k-mer (newest base in
// bits 1:0, bits above 2k zero), the pair sum over the 16 dimer counts of
// c*(c-1), and dust_flag = (pair_sum >= min_pair_sum) when k > 2. An N
// base yields nothing and restarts the window; read_end restarts it after the
// base is handled. kmer_length is clamped to 2..MAX_K; writing it restarts the
// window. Write configuration only while the block is idle.
module kmer_window_dust_filter #(
  parameter int MAX_K = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  kwdf_pkg::kwdf_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output kwdf_pkg::kwdf_out_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [kwdf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kwdf_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import kwdf_pkg::*;

  localparam int WIN_W = 2 * MAX_K;
  localparam int POS_W = $clog2(WIN_W);

  // Configuration
  logic [KLEN_W-1:0] kmer_len_r;
  logic [PSUM_W-1:0] min_psum_r;
  logic [KLEN_W-1:0] k_eff;
  logic              klen_wr;

  // Stream state
  logic [WIN_W-1:0]  window_r;
  logic [WIN_W-1:0]  window_nxt;
  logic [WIN_W-1:0]  win_mask;
  logic [KLEN_W-1:0] clean_run_r;
  logic [KLEN_W-1:0] clean_run_nxt;

  // Handshake and result
  logic              in_accept;
  logic              base_is_n;
  logic              emit;
  logic              stream_clr;
  logic [POS_W-1:0]  old_pos;
  logic [PSUM_W-1:0] pair_sum_nxt;
  logic              out_valid_r;
  kwdf_out_t         out_data_r;
  kwdf_dimer_ctl_t   dimer_ctl;

  // Clamp k into 2..MAX_K.
  always_comb begin
    if (kmer_len_r < KLEN_MIN) begin
      k_eff = KLEN_MIN;
    end else if (kmer_len_r > KLEN_W'(MAX_K)) begin
      k_eff = KLEN_W'(MAX_K);
    end else begin
      k_eff = kmer_len_r;
    end
  end

  assign klen_wr = cfg_we && (cfg_index == REG_KMER_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_len_r <= KLEN_RESET;
      min_psum_r <= MIN_PSUM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KMER_LENGTH:  kmer_len_r <= cfg_wdata[KLEN_W-1:0];
        REG_MIN_PAIR_SUM: min_psum_r <= cfg_wdata[PSUM_W-1:0];
        default: ;
      endcase
    end
  end

  // Take a new base unless a finished result is still held back.
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign base_is_n = in_data.base[BASE_W-1];

  // Keep only the low 2k bits of the window.
  for (genvar j = 0; j < WIN_W; j++) begin : g_mask
    assign win_mask[j] = (KLEN_W'(j / 2) < k_eff);
  end

  assign window_nxt    = {window_r[WIN_W-3:0], in_data.base[1:0]} & win_mask;
  assign clean_run_nxt = (clean_run_r < k_eff) ? clean_run_r + KLEN_W'(1) : clean_run_r;
  assign emit          = !base_is_n && (clean_run_nxt == k_eff);

  // Oldest dimer sits in bits 2k-1 .. 2k-4 of the full window.
  assign old_pos = POS_W'({k_eff - KLEN_MIN, 1'b0});

  // Restart on N, at end of read (after this base is scored) and on a k write.
  assign stream_clr = (in_accept && (base_is_n || in_data.read_end)) || klen_wr;

  always_comb begin
    dimer_ctl.upd     = in_accept && !base_is_n;
    dimer_ctl.clr     = stream_clr;
    dimer_ctl.dec_en  = clean_run_r >= k_eff;
    dimer_ctl.dec_idx = window_r[old_pos +: DIMER_W];
    dimer_ctl.inc_en  = clean_run_r != '0;
    dimer_ctl.inc_idx = {window_r[1:0], in_data.base[1:0]};
  end

  kwdf_dimer_bank u_dimer_bank (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (dimer_ctl),
    .pair_sum_nxt (pair_sum_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || stream_clr) begin
      window_r    <= '0;
      clean_run_r <= '0;
    end else if (in_accept) begin
      window_r    <= window_nxt;
      clean_run_r <= clean_run_nxt;
    end
  end

  // Result register: drop a taken result, load a new one on each scoring transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= emit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      out_data_r.kmer_bits <= KMER_W'(window_nxt);
      out_data_r.pair_sum  <= pair_sum_nxt;
      out_data_r.dust_flag <= (k_eff > KLEN_MIN) && (pair_sum_nxt >= min_psum_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_run_within_k : assert property (@(posedge clk) disable iff (!rst_n)
    clean_run_r <= k_eff)
    else $error("clean run exceeds window length");

  a_n_no_result : assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && base_is_n |=> !out_valid_r)
    else $error("N base produced a result");

  a_read_end_restart : assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.read_end |=> clean_run_r == '0)
    else $error("window not restarted after end of read");
`endif

endmodule

>>> dv/kwdf_checker.sv
// Scoreboard for the k-mer window low-complexity filter: tracks window state,
// predicts each result and compares every output transfer against it.
// Depends on kwdf_pkg.
module kwdf_checker #(
  parameter int MAX_K = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  kwdf_pkg::kwdf_in_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  kwdf_pkg::kwdf_out_t             out_data,
  input  logic                            cfg_we,
  input  logic [kwdf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kwdf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import kwdf_pkg::*;

  logic [KLEN_W-1:0] klen;
  logic [PSUM_W-1:0] min_psum;
  logic [KMER_W-1:0] win;
  int unsigned       clean_run;
  int unsigned       dimers [NUM_DIMERS];
  int unsigned       psum;

  kwdf_out_t expected_kmers [$];

  task automatic restart_window();
    win = '0;
    clean_run = 0;
    foreach (dimers[i]) dimers[i] = 0;
    psum = 0;
  endtask

  function automatic int unsigned clamped_k();
    int unsigned k;
    k = klen;
    if (k < 2) k = 2;
    if (k > MAX_K) k = MAX_K;
    return k;
  endfunction

  // Shift one base into the window and queue the result it produces, if any.
  task automatic advance_window(input kwdf_in_t item);
    int unsigned       k;
    logic [3:0]        old_d;
    logic [3:0]        new_d;
    logic [KMER_W-1:0] mask;
    kwdf_out_t         res;
    k = clamped_k();
    if (item.base >= 3'd4) begin
      restart_window();
      return;
    end
    if (clean_run >= k) begin
      old_d = 4'(win >> (2 * (k - 2)));
      if (dimers[old_d] > 0) begin
        dimers[old_d]--;
        psum -= 2 * dimers[old_d];
      end
    end
    if (clean_run >= 1) begin
      new_d = {win[1:0], item.base[1:0]};
      psum += 2 * dimers[new_d];
      dimers[new_d]++;
    end
    mask = (k >= 32) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
    win = ((win << 2) | KMER_W'(item.base)) & mask;
    if (clean_run < k) clean_run++;
    if (clean_run == k) begin
      res.kmer_bits = win;
      res.pair_sum  = PSUM_W'(psum);
      res.dust_flag = (k > 2) && (psum >= min_psum);
      expected_kmers.push_back(res);
    end
    if (item.read_end) restart_window();
  endtask

  task automatic check_result(input kwdf_out_t got);
    kwdf_out_t want;
    if (expected_kmers.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual %h", $time, got);
      fail_count++;
      return;
    end
    want = expected_kmers.pop_front();
    if (got.kmer_bits !== want.kmer_bits) begin
      $display("%0t: kmer_bits mismatch: expected %h actual %h",
               $time, want.kmer_bits, got.kmer_bits);
      fail_count++;
    end
    if (got.pair_sum !== want.pair_sum) begin
      $display("%0t: pair_sum mismatch: expected %0d actual %0d",
               $time, want.pair_sum, got.pair_sum);
      fail_count++;
    end
    if (got.dust_flag !== want.dust_flag) begin
      $display("%0t: dust_flag mismatch: expected %b actual %b",
               $time, want.dust_flag, got.dust_flag);
      fail_count++;
    end
  endtask

  // Drain before predicting: a result leaving at this edge never belongs to the
  // base entering at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      klen = KLEN_RESET;
      min_psum = MIN_PSUM_RESET;
      restart_window();
      expected_kmers.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) advance_window(in_data);
      if (cfg_we) begin
        if (cfg_index == REG_KMER_LENGTH) begin
          klen = cfg_wdata[KLEN_W-1:0];
          restart_window();
        end else if (cfg_index == REG_MIN_PAIR_SUM) begin
          min_psum = cfg_wdata;
        end
      end
    end
    pending = expected_kmers.size();
  end

endmodule

>>> dv/kmer_window_dust_filter_tb.sv
// Top of the k-mer window filter testbench: clock, reset, base stream, stalls
// and register writes, plus the final verdict.
// Depends on kwdf_pkg, kmer_window_dust_filter and kwdf_checker.
module kmer_window_dust_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kwdf_pkg::*;

  localparam int MAX_K      = 32;
  localparam int N_PHASES   = 12;
  localparam int PHASE_LEN  = 115;
  localparam int IDLE_PCT   = 36;
  localparam int LIMIT      = 200000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  kwdf_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  kwdf_out_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int  fail_count;
  int  chk_pending;
  int  cycle_cnt = 0;
  int  sent      = 0;
  // Set for one whole phase: neither side idles while it is high.
  bit  calm      = 1'b0;

  // Register settings per phase: the kmer_length values cover below-range,
  // both ends of the legal range and above-range writes.
  int unsigned ph_k   [10] = '{0, 1, 2, 3, 33, 63, 32, 16, 8, 4};
  int unsigned ph_thr [10] = '{0, 1023, 5, 2, 1023, 0, 40, 28, 12, 4};

  kmer_window_dust_filter #(.MAX_K(MAX_K)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  kwdf_checker #(.MAX_K(MAX_K)) chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (chk_pending)
  );

  always #2 clk = ~clk;

  // Receiver back-pressure: stall at random except during the calm phase.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Offer one base and hold it until the block takes it. A random gap comes
  // first; the transfer completes at the edge where in_stall is seen low.
  task automatic send_item(input logic [BASE_W-1:0] b, input logic re);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= kwdf_in_t'{base: b, read_end: re};
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // Write both registers on back-to-back cycles, keeping the write enable high
  // across them. Upper data bits of the kmer_length write are random junk that
  // the block must mask off.
  task automatic set_config(input int unsigned kraw, input int unsigned thr);
    cfg_we    <= 1'b1;
    cfg_index <= REG_KMER_LENGTH;
    cfg_wdata <= {4'($urandom), 6'(kraw)};
    @(posedge clk);
    cfg_index <= REG_MIN_PAIR_SUM;
    cfg_wdata <= 10'(thr);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Drop valid, wait for every predicted result to drain, then let the
  // pipeline settle before touching registers.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (chk_pending != 0);
    repeat (3) @(posedge clk);
  endtask

  // One read of random length. Most reads are clean sequence, often repetitive
  // so the pair sum climbs; a few carry an N inside, and some are pure noise
  // with any code and random read_end flags.
  task automatic send_read(input int unsigned ek);
    int unsigned       len;
    int unsigned       mode;
    int unsigned       i;
    logic [1:0]        a;
    logic [1:0]        c;
    logic [BASE_W-1:0] b;
    logic              re;
    len  = $urandom_range(1, ek + 24);
    mode = $urandom_range(0, 9);
    a    = 2'($urandom);
    c    = 2'($urandom);
    for (i = 0; i < len; i++) begin
      case (mode)
        0:       b = 3'($urandom);
        1, 2:    b = {1'b0, a};
        3, 4:    b = {1'b0, (i % 2 == 1) ? c : a};
        5:       b = {1'b0, a[1], 1'($urandom)};
        default: b = {1'b0, 2'($urandom)};
      endcase
      if (mode != 0 && $urandom_range(99) < 2) b = 3'($urandom_range(4, 7));
      if (mode == 0) re = ($urandom_range(0, 9) == 0);
      else re = (i == len - 1);
      send_item(b, re);
    end
  endtask

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("kmer_window_dust_filter_tb failed");
    $finish;
  end

  initial begin
    int unsigned ph;
    int unsigned kraw;
    int unsigned thr;
    int unsigned ek;
    int          phase_start;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, k = 3: every base code, two of the four N codes, a low-complexity
    // run, a read end that lands on a result and a one-base read.
    set_config(3, 1);
    send_item(3'd0, 1'b0);
    send_item(3'd1, 1'b0);
    send_item(3'd2, 1'b0);
    send_item(3'd3, 1'b0);
    send_item(3'd4, 1'b0);
    send_item(3'd0, 1'b0);
    send_item(3'd0, 1'b0);
    send_item(3'd0, 1'b0);
    send_item(3'd0, 1'b0);
    send_item(3'd7, 1'b0);
    send_item(3'd3, 1'b0);
    send_item(3'd3, 1'b0);
    send_item(3'd3, 1'b1);
    send_item(3'd2, 1'b1);
    wait_idle();

    // Directed, k = 2 with a zero threshold: the flag must stay low anyway.
    set_config(2, 0);
    send_item(3'd1, 1'b0);
    send_item(3'd2, 1'b0);
    send_item(3'd3, 1'b1);
    send_item(3'd0, 1'b0);
    send_item(3'd0, 1'b0);
    send_item(3'd5, 1'b0);
    wait_idle();

    // Random phases, each under its own register setting.
    for (ph = 0; ph < N_PHASES; ph++) begin
      if (ph < 10) begin
        kraw = ph_k[ph];
        thr  = ph_thr[ph];
      end else begin
        kraw = $urandom_range(2, MAX_K);
        thr  = $urandom_range(0, 4 * kraw);
      end
      calm = (ph == 5);
      set_config(kraw, thr);
      ek = (kraw < 2) ? 2 : (kraw > MAX_K) ? MAX_K : kraw;
      phase_start = sent;
      while (sent - phase_start < PHASE_LEN) send_read(ek);
      wait_idle();
    end

    // Let any stray output surface before the verdict.
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && chk_pending == 0) begin
      $display("kmer_window_dust_filter_tb passed");
    end else begin
      $display("kmer_window_dust_filter_tb failed");
    end
    $finish;
  end

endmodule
